@@ rtl/core/dual_priority_queue_assert.svh @@
// Assertion macros for the dual-key priority queue.
// Used by dual_priority_queue.sv; needs clk and rst in the including scope.
`ifndef DUAL_PRIORITY_QUEUE_ASSERT_SVH
`define DUAL_PRIORITY_QUEUE_ASSERT_SVH

// Condition holds in the same cycle as the trigger
`define DPQ_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("dpq check failed");

// Condition holds in the cycle after the trigger
`define DPQ_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("dpq check failed");

`endif

@@ rtl/core/dpq_pkg.sv @@
// Shared types and constants of the dual-key priority queue.
// No dependencies; imported by dual_priority_queue.
package dpq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ACT_W     = 3;
  localparam int TAG_W     = 16;
  localparam int PRIO_W    = 32;
  localparam int ORD_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 5;
  localparam int IN_W      = 88;
  localparam int OUT_W     = 24;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ENQ     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ_A   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEQ_B   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEQ_OLD = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DUP   = 2'd3;

  // One stored entry
  typedef struct packed {
    logic [ORD_W-1:0]  order;
    logic [PRIO_W-1:0] prio_b;
    logic [PRIO_W-1:0] prio_a;
    logic [TAG_W-1:0]  tag;
  } slot_t;

endpackage

@@ rtl/core/dual_priority_queue.sv @@
// Dual-key priority queue: top level with slot memory and scan sequencer.
// Enqueue and dequeue scan the slot memory one slot per cycle through a single
// compare unit; the next beat is accepted once the result has been loaded into
// the output register. Clear and unused actions skip the scan.
// Reset (rst, synchronous) empties the queue, zeroes the order stamp, drops
// any pending result; slot payload memory is not cleared.
module dual_priority_queue
  import dpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // [2:0] action, [18:3] item_tag, [50:19] priority_a, [82:51] priority_b
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // [15:0] out_tag, [17:16] status, [22:18] entry_count
  output logic [OUT_W-1:0] m_tdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT, S_RESULT} state_t;

  state_t             state;
  logic [DEPTH-1:0]   slot_valid;
  slot_t              mem [DEPTH];
  slot_t              rd_data;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  slot_t              mem_wdata;

  logic [ORD_W-1:0]   next_order;
  logic [CW-1:0]      occupancy;

  // Latched input beat
  logic [ACT_W-1:0]   act_r;
  slot_t              in_r;

  // Scan control
  logic [IW-1:0]      cnt;
  logic               cmp_vld;
  logic [IW-1:0]      cmp_idx;

  // Scan results
  logic               dup;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic               found;
  logic [IW-1:0]      best_idx;
  logic [TAG_W-1:0]   best_tag;
  logic [PRIO_W-1:0]  best_key;
  logic [ORD_W-1:0]   best_age;

  // Result held for the output stage
  logic [TAG_W-1:0]   res_tag;
  logic [STAT_W-1:0]  res_status;

  // Compare unit
  logic [PRIO_W-1:0]  key_i;
  logic [ORD_W-1:0]   age_i;
  logic               key_gt;
  logic               key_eq;
  logic               better;
  logic               s_beat;
  slot_t              in_slot;

  // Accept only when idle and out of reset
  assign s_tready = (state == S_IDLE) && !rst;
  assign s_beat   = s_tvalid && s_tready;

  assign in_slot.tag    = s_tdata[18:3];
  assign in_slot.prio_a = s_tdata[50:19];
  assign in_slot.prio_b = s_tdata[82:51];
  assign in_slot.order  = '0;

  assign key_i  = (act_r == ACT_DEQ_A) ? rd_data.prio_a : rd_data.prio_b;
  assign age_i  = next_order - rd_data.order;
  assign key_gt = $signed(key_i) > $signed(best_key);
  assign key_eq = (key_i == best_key);
  assign better = !found ||
                  ((act_r == ACT_DEQ_OLD) ? (age_i > best_age)
                                          : (key_gt || (key_eq && (age_i > best_age))));

  // Write a new entry at commit of a successful enqueue
  always_comb begin
    mem_we          = (state == S_COMMIT) && (act_r == ACT_ENQ) && !dup && free_found;
    mem_waddr       = free_idx;
    mem_wdata       = in_r;
    mem_wdata.order = next_order;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[cnt];
  end

  // Sequencer, scan bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      next_order <= '0;
      occupancy  <= '0;
      cnt        <= '0;
      cmp_vld    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // Compare the slot read in this cycle on the next one
      cmp_vld <= (state == S_SCAN);
      cmp_idx <= cnt;

      // Drop the result once taken, unless a new one loads in its place
      if (m_tvalid && m_tready && (state != S_RESULT)) begin
        m_tvalid <= 1'b0;
      end

      // Evaluate the entry read in the previous cycle
      if (cmp_vld) begin
        if (slot_valid[cmp_idx]) begin
          if (act_r == ACT_ENQ) begin
            if (rd_data.tag == in_r.tag) begin
              dup <= 1'b1;
            end
          end else if (better) begin
            found    <= 1'b1;
            best_idx <= cmp_idx;
            best_tag <= rd_data.tag;
            best_key <= key_i;
            best_age <= age_i;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (s_beat) begin
            act_r      <= s_tdata[2:0];
            in_r       <= in_slot;
            cnt        <= '0;
            dup        <= 1'b0;
            free_found <= 1'b0;
            found      <= 1'b0;
            res_tag    <= '0;
            res_status <= ST_OK;
            if (s_tdata[2:0] == ACT_ENQ || s_tdata[2:0] == ACT_DEQ_A ||
                s_tdata[2:0] == ACT_DEQ_B || s_tdata[2:0] == ACT_DEQ_OLD) begin
              state <= S_SCAN;
            end else begin
              if (s_tdata[2:0] == ACT_CLEAR) begin
                slot_valid <= '0;
                occupancy  <= '0;
              end
              state <= S_RESULT;
            end
          end
        end
        S_SCAN: begin
          // Advance one slot per cycle through the memory
          if (cnt == IW'(DEPTH - 1)) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (act_r == ACT_ENQ) begin
            if (dup) begin
              res_status <= ST_DUP;
            end else if (!free_found) begin
              res_status <= ST_FULL;
            end else begin
              slot_valid[free_idx] <= 1'b1;
              next_order           <= next_order + 1'b1;
              occupancy            <= occupancy + 1'b1;
            end
          end else if (!found) begin
            res_status <= ST_EMPTY;
          end else begin
            res_tag              <= best_tag;
            slot_valid[best_idx] <= 1'b0;
            occupancy            <= occupancy - 1'b1;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, CNT_W'(occupancy), res_status, res_tag};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "dual_priority_queue_assert.svh"

  `DPQ_ASSERT_NEXT(a_busy_after_beat, s_beat, !s_tready)
  `DPQ_ASSERT_SAME(a_occ_bound, 1'b1, occupancy <= CW'(DEPTH))
  `DPQ_ASSERT_SAME(a_occ_matches_valid, 1'b1, $countones(slot_valid) == occupancy)
  `DPQ_ASSERT_NEXT(a_deq_shrinks,
    state == S_COMMIT && act_r != ACT_ENQ && found,
    occupancy == $past(occupancy) - 1'b1)
  `DPQ_ASSERT_NEXT(a_dup_keeps,
    state == S_COMMIT && act_r == ACT_ENQ && dup,
    occupancy == $past(occupancy) && next_order == $past(next_order))

endmodule

@@ verif/dual_priority_queue_tb.sv @@
// Self-checking testbench for the dual-key priority queue (dual_priority_queue).
// Depends on dpq_pkg; drives the input stream, models the queue and checks
// every output beat.
`timescale 1ns / 100ps

module dual_priority_queue_tb;
  import dpq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int PAD_W       = IN_W - ACT_W - TAG_W - 2 * PRIO_W;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 920;

  localparam logic [ACT_W-1:0]  ACT_UNUSED_LO = 3'd5;
  localparam logic [ACT_W-1:0]  ACT_UNUSED_HI = 3'd7;
  localparam logic [PRIO_W-1:0] PRIO_MIN      = 32'h8000_0000;
  localparam logic [PRIO_W-1:0] PRIO_MAX      = 32'h7FFF_FFFF;
  localparam logic [PRIO_W-1:0] PRIO_ONE      = 32'h0001_0000;
  localparam logic [PRIO_W-1:0] PRIO_NEG_LSB  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } queue_result_t;

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata;
  logic            m_tvalid;
  logic            m_tready;
  logic [OUT_W-1:0] m_tdata;

  // Shadow copy of the queue contents
  logic              shadow_valid [DEPTH];
  logic [TAG_W-1:0]  shadow_tag   [DEPTH];
  logic [PRIO_W-1:0] shadow_prio_a[DEPTH];
  logic [PRIO_W-1:0] shadow_prio_b[DEPTH];
  logic [ORD_W-1:0]  shadow_stamp [DEPTH];
  logic [ORD_W-1:0]  shadow_next_stamp;
  int                shadow_count;

  queue_result_t expected_results[$];
  int            error_count;
  bit            tx_idle_en;
  bit            rx_idle_en;
  int            rx_hold;
  int            rx_stall;

  dual_priority_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("MISMATCH at %0t: %s expected 0x%0h got 0x%0h", $time, what, exp_v, got_v);
    error_count++;
  endtask

  // Age of an entry counts up from its stamp, modulo 2^32
  function automatic bit is_older(int i, int j);
    logic [ORD_W-1:0] age_i;
    logic [ORD_W-1:0] age_j;
    age_i = shadow_next_stamp - shadow_stamp[i];
    age_j = shadow_next_stamp - shadow_stamp[j];
    return age_i > age_j;
  endfunction

  // Find the entry a dequeue removes; -1 when the queue is empty
  function automatic int select_victim(logic [ACT_W-1:0] act);
    int best;
    logic signed [PRIO_W-1:0] key_i;
    logic signed [PRIO_W-1:0] key_b;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!shadow_valid[i]) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (act == ACT_DEQ_OLD) begin
        if (is_older(i, best)) best = i;
      end else begin
        key_i = (act == ACT_DEQ_A) ? shadow_prio_a[i] : shadow_prio_b[i];
        key_b = (act == ACT_DEQ_A) ? shadow_prio_a[best] : shadow_prio_b[best];
        if (key_i > key_b || (key_i == key_b && is_older(i, best))) best = i;
      end
    end
    return best;
  endfunction

  // Apply one accepted beat to the shadow queue and queue up its result
  function automatic void apply_action(logic [ACT_W-1:0] act, logic [TAG_W-1:0] tag,
                                       logic [PRIO_W-1:0] pa, logic [PRIO_W-1:0] pb);
    queue_result_t res;
    int            free_slot;
    int            victim;
    bit            dup;
    res       = '0;
    free_slot = -1;
    dup       = 1'b0;
    if (act == ACT_ENQ) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (shadow_valid[i]) begin
          if (shadow_tag[i] == tag) dup = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (dup) begin
        res.status = ST_DUP;
      end else if (free_slot < 0) begin
        res.status = ST_FULL;
      end else begin
        shadow_valid[free_slot]  = 1'b1;
        shadow_tag[free_slot]    = tag;
        shadow_prio_a[free_slot] = pa;
        shadow_prio_b[free_slot] = pb;
        shadow_stamp[free_slot]  = shadow_next_stamp;
        shadow_next_stamp++;
        shadow_count++;
      end
    end else if (act == ACT_DEQ_A || act == ACT_DEQ_B || act == ACT_DEQ_OLD) begin
      victim = select_victim(act);
      if (victim < 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.tag              = shadow_tag[victim];
        shadow_valid[victim] = 1'b0;
        shadow_count--;
      end
    end else if (act == ACT_CLEAR) begin
      for (int i = 0; i < DEPTH; i++) shadow_valid[i] = 1'b0;
      shadow_count = 0;
    end
    res.count = CNT_W'(shadow_count);
    expected_results.push_back(res);
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offer one beat, hold it until accepted, then update the shadow queue
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [TAG_W-1:0] tag,
                           input logic [PRIO_W-1:0] pa, input logic [PRIO_W-1:0] pb);
    int gap;
    gap = pick_gap(tx_idle_en);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, pb, pa, tag, act};
    do @(posedge clk); while (!s_tready);
    apply_action(act, tag, pa, pb);
  endtask

  // Small pool for duplicates, held tags now and then, otherwise any tag
  function automatic logic [TAG_W-1:0] rand_tag();
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 40) return TAG_W'($urandom_range(23));
    if (r < 50 && shadow_count > 0) begin
      k = $urandom_range(DEPTH - 1);
      while (!shadow_valid[k]) k = (k + 1) % DEPTH;
      return shadow_tag[k];
    end
    return TAG_W'($urandom);
  endfunction

  // Extremes, a narrow band that forces ties, or any value
  function automatic logic [PRIO_W-1:0] rand_prio();
    int r;
    r = $urandom_range(99);
    if (r < 8) return PRIO_MIN;
    if (r < 16) return PRIO_MAX;
    if (r < 45) return PRIO_W'($urandom_range(7)) - PRIO_W'(4);
    return PRIO_W'($urandom);
  endfunction

  task automatic test_empty_queue();
    send_item(ACT_DEQ_A, '0, '0, '0);
    send_item(ACT_DEQ_B, '0, '0, '0);
    send_item(ACT_DEQ_OLD, '0, '0, '0);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      send_item(ACT_W'(a), 16'hFFFF, PRIO_MAX, PRIO_MIN);
  endtask

  task automatic test_extremes_and_ties();
    send_item(ACT_ENQ, 16'h0000, PRIO_MIN, PRIO_MAX);
    send_item(ACT_ENQ, 16'hFFFF, PRIO_MAX, PRIO_MIN);
    send_item(ACT_ENQ, 16'h1234, '0, PRIO_NEG_LSB);
    // same tag again is rejected
    send_item(ACT_ENQ, 16'h0000, PRIO_ONE, PRIO_ONE);
    send_item(ACT_ENQ, 16'h0010, PRIO_ONE, PRIO_ONE);
    send_item(ACT_ENQ, 16'h0011, PRIO_ONE, PRIO_ONE);
    send_item(ACT_DEQ_A, '0, '0, '0);
    send_item(ACT_DEQ_B, '0, '0, '0);
    // equal priority A: earlier enqueue wins
    send_item(ACT_DEQ_A, '0, '0, '0);
    send_item(ACT_DEQ_OLD, '0, '0, '0);
    send_item(ACT_DEQ_B, '0, '0, '0);
    send_item(ACT_DEQ_OLD, '0, '0, '0);
  endtask

  task automatic test_clear();
    send_item(ACT_ENQ, 16'h0005, PRIO_ONE, '0);
    send_item(ACT_ENQ, 16'h0006, '0, PRIO_ONE);
    send_item(ACT_CLEAR, '0, '0, '0);
    send_item(ACT_DEQ_OLD, '0, '0, '0);
    // tag freed by clear is accepted again
    send_item(ACT_ENQ, 16'h0005, PRIO_MAX, PRIO_MAX);
  endtask

  // Stall the output for a long stretch while filling the queue to the top
  task automatic test_full_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_item(ACT_CLEAR, '0, '0, '0);
    rx_hold = HOLD_CYCLES;
    for (int i = 0; i < DEPTH; i++)
      send_item(ACT_ENQ, TAG_W'(16'hA000 + i), rand_prio(), rand_prio());
    // duplicate is checked ahead of full
    send_item(ACT_ENQ, 16'hA000, '0, '0);
    send_item(ACT_ENQ, 16'hB000, '0, '0);
    send_item(ACT_DEQ_A, '0, '0, '0);
    send_item(ACT_DEQ_B, '0, '0, '0);
    send_item(ACT_DEQ_OLD, '0, '0, '0);
  endtask

  // Alternate fill-biased and drain-biased runs with random content
  task automatic test_random(input int n_items);
    int               sent;
    int               run_left;
    int               r;
    bit               filling;
    logic [ACT_W-1:0] act;
    sent     = 0;
    run_left = 0;
    filling  = 1'b0;
    while (sent < n_items) begin
      if (sent % 100 == 0) begin
        tx_idle_en = ($urandom_range(3) != 0) && (sent / 100 != 3);
        rx_idle_en = ($urandom_range(3) != 0) && (sent / 100 != 3);
      end
      if (run_left == 0) begin
        filling  = !filling;
        run_left = $urandom_range(50, 10);
      end
      r = $urandom_range(99);
      if (r < 2)
        act = ACT_CLEAR;
      else if (r < 5)
        act = ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      else if (r < (filling ? 70 : 35))
        act = ACT_ENQ;
      else
        act = ACT_W'($urandom_range(ACT_DEQ_OLD, ACT_DEQ_A));
      send_item(act, rand_tag(), rand_prio(), rand_prio());
      sent++;
      run_left--;
    end
  endtask

  // Output side: long hold-off on request, otherwise random stalls
  initial begin
    m_tready = 1'b0;
    rx_stall = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        m_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_tready <= 1'b1;
        rx_stall = pick_gap(rx_idle_en);
      end
    end
  end

  // Check each output beat against the oldest expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", '0, 32'(m_tdata));
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[15:0] != want.tag)
          report_mismatch("out_tag", 32'(want.tag), 32'(m_tdata[15:0]));
        if (m_tdata[17:16] != want.status)
          report_mismatch("status", 32'(want.status), 32'(m_tdata[17:16]));
        if (m_tdata[22:18] != want.count)
          report_mismatch("entry_count", 32'(want.count), 32'(m_tdata[22:18]));
      end
    end
  end

  // Hard stop
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int drain_cycles;
    rst               = 1'b1;
    s_tvalid          = 1'b0;
    s_tdata           = '0;
    error_count       = 0;
    tx_idle_en        = 1'b1;
    rx_idle_en        = 1'b1;
    rx_hold           = 0;
    shadow_next_stamp = '0;
    shadow_count      = 0;
    for (int i = 0; i < DEPTH; i++) shadow_valid[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_extremes_and_ties();
    test_clear();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_full_backpressure();
    test_random(RANDOM_ITEMS);

    // Drain outstanding results, then let the pipe settle
    s_tvalid <= 1'b0;
    rx_idle_en = 1'b0;
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", '0, 32'(expected_results.size()));
    repeat (2 * DEPTH + 8) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
